>>> rtl/core/rcba_pkg.sv
// Package for the reference-counted block allocator.
// Holds the pool geometry, request and status codes and the reset word of the store.
// No dependencies; imported by rcba_store, refcounted_block_allocator_top and the testbench.
`default_nettype none

package rcba_pkg;

  // Pool geometry; BlocksPerChunk must be a power of two
  localparam int BlocksPerChunk = 64;
  localparam int MaxChunks      = 4;

  localparam int LOCAL_W  = $clog2(BlocksPerChunk);
  localparam int CHUNK_W  = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int SLOT_W   = CHUNK_W + LOCAL_W;
  localparam int DEPTH    = MaxChunks * BlocksPerChunk;
  localparam int CIU_W    = $clog2(MaxChunks + 1);
  localparam int UCNT_W   = $clog2(BlocksPerChunk + 1);
  localparam int WORD_W   = 32;

  // Payload field widths
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int TDATA_W  = 48;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SUB   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFERENCED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd4;

  // Access to the link/count store for one operation
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    logic [WORD_W-1:0] wr_data;
  } store_req_t;

  // Word held by a slot that was never written: next in-chunk index, all ones at the end
  function automatic logic [WORD_W-1:0] reset_word(input logic [SLOT_W-1:0] slot);
    logic [LOCAL_W-1:0] loc;
    loc = slot[LOCAL_W-1:0];
    if (loc == LOCAL_W'(BlocksPerChunk - 1)) begin
      return '1;
    end else begin
      return WORD_W'(loc) + WORD_W'(1);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rcba_store.sv
// Link/count word store of the allocator: one word per block.
// Registered read; per-entry valid bits give the reset contents without a clearing pass.
// Depends on rcba_pkg.
`default_nettype none

module rcba_store
  import rcba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire store_req_t        req_i,
  output logic [WORD_W-1:0]      rd_data_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [WORD_W-1:0] rd_word_q;
  logic              rd_valid_q;
  logic [SLOT_W-1:0] rd_addr_q;

  // Memory array: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem[req_i.addr];
    end
  end

  // Written flags, cleared together at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
        rd_addr_q  <= req_i.addr;
      end
    end
  end

  // Unwritten entries read as their reset link
  assign rd_data_o = rd_valid_q ? rd_word_q : reset_word(rd_addr_q);

endmodule

`default_nettype wire

>>> rtl/core/refcounted_block_allocator_top.sv
// Reference-counted block allocator, top level.
// Holds the request sequencer, chunk bookkeeping and output register; uses rcba_store.
// Depends on rcba_pkg.
`default_nettype none

// Each request is done in two steps: the transfer cycle issues the read of the addressed
// word from the single-port link/count store, and the execute step then does the update
// through the one shared 32-bit add/subtract unit and writes the store back. The
// execute step waits while the previous result is still held in the output register.
// No clearing pass is needed after reset: unwritten words read as their reset links.
// Alloc picks the lowest chunk in use that can still give a block, in parallel.
module refcounted_block_allocator_top
  import rcba_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // req_type[2:0], block_index[10:3], ref_delta[42:11], zero fill above
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // status[2:0], granted_index[10:3], prior_count[42:11], zero fill above
  output logic [TDATA_W-1:0]      m_axis_tdata
);

  localparam logic SEQ_IDLE = 1'b0;
  localparam logic SEQ_EXEC = 1'b1;

  logic                state_q, state_d;
  logic [REQ_W-1:0]    req_q;
  logic [WORD_W-1:0]   delta_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CHUNK_W-1:0]  chunk_q;
  logic                open_q;
  logic [STATUS_W-1:0] pre_status_q;

  logic [WORD_W-1:0]   head_q [MaxChunks];
  logic [UCNT_W-1:0]   used_q [MaxChunks];
  logic [CIU_W-1:0]    ciu_q;

  logic                out_valid_q;
  logic [TDATA_W-1:0]  out_data_q;

  // Input fields
  logic [REQ_W-1:0]    in_req;
  logic [IDX_W-1:0]    in_idx;
  logic [WORD_W-1:0]   in_delta;
  assign in_req   = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[10:3];
  assign in_delta = s_axis_tdata[42:11];

  logic accept;
  logic exec_go;
  assign s_axis_tready = (state_q == SEQ_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state_q == SEQ_EXEC) && (!out_valid_q || m_axis_tready);

  // Alloc chunk pick: lowest chunk in use with room and a sane head
  logic [MaxChunks-1:0] can_give;
  logic                 pick_found;
  logic [CHUNK_W-1:0]   pick_c;
  always_comb begin
    pick_found = 1'b0;
    pick_c     = '0;
    for (int c = 0; c < MaxChunks; c++) begin
      can_give[c] = (CIU_W'(c) < ciu_q) &&
                    (used_q[c] < UCNT_W'(BlocksPerChunk)) &&
                    (head_q[c] < WORD_W'(BlocksPerChunk));
      if (!pick_found && can_give[c]) begin
        pick_found = 1'b1;
        pick_c     = CHUNK_W'(c);
      end
    end
  end

  // Request decode at transfer time
  logic [CHUNK_W-1:0]  dec_chunk;
  logic [SLOT_W-1:0]   dec_slot;
  logic                dec_open;
  logic [STATUS_W-1:0] dec_status;
  logic                dec_rd;
  logic [IDX_W-1:0]    idx_chunk;
  assign idx_chunk = in_idx >> LOCAL_W;

  always_comb begin
    dec_chunk  = '0;
    dec_slot   = '0;
    dec_open   = 1'b0;
    dec_status = ST_OK;
    dec_rd     = 1'b0;
    case (in_req)
      REQ_ALLOC: begin
        if (pick_found) begin
          dec_chunk = pick_c;
          dec_rd    = 1'b1;
        end else if (ciu_q < CIU_W'(MaxChunks)) begin
          dec_chunk = CHUNK_W'(ciu_q);
          dec_open  = 1'b1;
          dec_rd    = 1'b1;
        end else begin
          dec_status = ST_FULL;
        end
        dec_slot = {dec_chunk, head_q[dec_chunk][LOCAL_W-1:0]};
      end
      REQ_FREE, REQ_ADD, REQ_SUB, REQ_READ: begin
        if (idx_chunk < IDX_W'(ciu_q)) begin
          dec_chunk = CHUNK_W'(idx_chunk);
          dec_slot  = SLOT_W'(in_idx);
          dec_rd    = 1'b1;
        end else begin
          dec_status = ST_RANGE;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // Link/count store
  store_req_t          st_req;
  logic [WORD_W-1:0]   word;

  rcba_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (st_req),
    .rd_data_o (word)
  );

  // Shared add/subtract unit; carry out set on subtract means no borrow
  logic              is_sub;
  logic [WORD_W:0]   sum;
  assign is_sub = (req_q == REQ_SUB);
  assign sum    = {1'b0, word} + {1'b0, (is_sub ? ~delta_q : delta_q)} +
                  (WORD_W + 1)'(is_sub);

  // Execute step: result and state updates
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_granted;
  logic [WORD_W-1:0]   res_before;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_data;
  logic                head_we, used_inc, used_dec;
  logic [WORD_W-1:0]   head_wdata;

  always_comb begin
    res_status  = pre_status_q;
    res_granted = '0;
    res_before  = '0;
    wr_en       = 1'b0;
    wr_data     = '0;
    head_we     = 1'b0;
    head_wdata  = '0;
    used_inc    = 1'b0;
    used_dec    = 1'b0;
    if (pre_status_q == ST_OK) begin
      case (req_q)
        REQ_ALLOC: begin
          res_granted = IDX_W'(slot_q);
          wr_en       = 1'b1;
          head_we     = 1'b1;
          head_wdata  = word;
          used_inc    = 1'b1;
        end
        REQ_FREE: begin
          if (word != '0) begin
            res_status = ST_REFERENCED;
          end else begin
            wr_en      = 1'b1;
            wr_data    = head_q[chunk_q];
            head_we    = 1'b1;
            head_wdata = WORD_W'(slot_q[LOCAL_W-1:0]);
            used_dec   = (used_q[chunk_q] != '0);
          end
        end
        REQ_ADD: begin
          res_before = word;
          wr_en      = 1'b1;
          wr_data    = sum[WORD_W-1:0];
        end
        REQ_SUB: begin
          res_before = word;
          if (!sum[WORD_W]) begin
            res_status = ST_UNDERFLOW;
          end else begin
            wr_en   = 1'b1;
            wr_data = sum[WORD_W-1:0];
          end
        end
        REQ_READ: begin
          res_before = word;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // Store port: read on transfer, write back on execute
  always_comb begin
    st_req.rd_en   = accept && dec_rd;
    st_req.wr_en   = exec_go && wr_en;
    st_req.addr    = (state_q == SEQ_IDLE) ? dec_slot : slot_q;
    st_req.wr_data = wr_data;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: if (accept)  state_d = SEQ_EXEC;
      SEQ_EXEC: if (exec_go) state_d = SEQ_IDLE;
      default:               state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latched request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q        <= in_req;
      delta_q      <= in_delta;
      slot_q       <= dec_slot;
      chunk_q      <= dec_chunk;
      open_q       <= dec_open;
      pre_status_q <= dec_status;
    end
  end

  // Chunk bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ciu_q <= '0;
      for (int c = 0; c < MaxChunks; c++) begin
        head_q[c] <= '0;
        used_q[c] <= '0;
      end
    end else if (exec_go) begin
      if (head_we) begin
        head_q[chunk_q] <= head_wdata;
      end
      if (used_inc) begin
        used_q[chunk_q] <= used_q[chunk_q] + UCNT_W'(1);
      end else if (used_dec) begin
        used_q[chunk_q] <= used_q[chunk_q] - UCNT_W'(1);
      end
      if (used_inc && open_q) begin
        ciu_q <= ciu_q + CIU_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_data_q <= {5'd0, res_before, res_granted, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> verif/refcounted_block_allocator_top_test.sv
// Self-checking testbench for refcounted_block_allocator_top: stream driver, response
// monitor and an in-bench allocator model that predicts every response.
// Depends on rcba_pkg and the allocator RTL; needs no files or arguments.
`default_nettype none

module refcounted_block_allocator_top_test
  import rcba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;
  localparam int PAYLOAD_W    = STATUS_W + IDX_W + WORD_W;
  localparam int PHASE_ITEMS  = 110;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] delta;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted;
    logic [WORD_W-1:0]   prior;
  } response_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // req_type[2:0], block_index[10:3], ref_delta[42:11], zero fill above
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // status[2:0], granted_index[10:3], prior_count[42:11], zero fill above
  logic [TDATA_W-1:0] m_axis_tdata;

  refcounted_block_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Allocator model state
  logic [WORD_W-1:0] block_word [DEPTH];
  logic [WORD_W-1:0] chunk_head [MaxChunks];
  int unsigned       chunk_used [MaxChunks];
  int unsigned       open_chunks;
  bit                block_held [DEPTH];

  request_t    pending_requests[$];
  response_t   expected_responses[$];
  request_t    in_flight;
  int unsigned send_gap_pct [4] = '{0, 88, 0, 38};
  int unsigned recv_stall_pct [4] = '{0, 0, 88, 38};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_issued = 0;
  int unsigned responses_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned status_seen [8];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_pool_model();
    for (int s = 0; s < DEPTH; s++) begin
      block_word[s] = (s % BlocksPerChunk == BlocksPerChunk - 1) ? '1 :
                      WORD_W'(s % BlocksPerChunk + 1);
      block_held[s] = 1'b0;
    end
    for (int c = 0; c < MaxChunks; c++) begin
      chunk_head[c] = '0;
      chunk_used[c] = 0;
    end
    open_chunks = 0;
  endfunction

  // A chunk with a head that is not a block index counts as full
  function automatic bit chunk_can_give(int unsigned c);
    return chunk_used[c] < BlocksPerChunk && chunk_head[c] < BlocksPerChunk;
  endfunction

  function automatic bit pool_exhausted();
    bit any_room;
    any_room = 1'b0;
    for (int c = 0; c < MaxChunks; c++) begin
      if (c < open_chunks && chunk_can_give(c)) any_room = 1'b1;
    end
    return open_chunks == MaxChunks && !any_room;
  endfunction

  function automatic logic [IDX_W-1:0] pop_free_block(int unsigned c);
    int unsigned slot;
    slot = c * BlocksPerChunk + chunk_head[c];
    chunk_head[c] = block_word[slot];
    block_word[slot] = '0;
    chunk_used[c]++;
    block_held[slot] = 1'b1;
    return IDX_W'(slot);
  endfunction

  // Applies one request to the model and returns the response it must produce
  function automatic response_t allocator_response(request_t rq);
    response_t         rsp;
    int unsigned       c;
    bit                done;
    logic [WORD_W-1:0] w;
    rsp.status  = ST_OK;
    rsp.granted = '0;
    rsp.prior   = '0;
    done = 1'b0;
    if (rq.kind == REQ_ALLOC) begin
      for (c = 0; c < open_chunks && !done; c++) begin
        if (chunk_can_give(c)) begin
          rsp.granted = pop_free_block(c);
          done = 1'b1;
        end
      end
      if (!done) begin
        if (open_chunks < MaxChunks) begin
          open_chunks++;
          rsp.granted = pop_free_block(open_chunks - 1);
        end else begin
          rsp.status = ST_FULL;
        end
      end
    end else if (rq.kind <= REQ_READ) begin
      c = rq.index / BlocksPerChunk;
      if (c >= open_chunks) begin
        rsp.status = ST_RANGE;
      end else begin
        w = block_word[rq.index];
        case (rq.kind)
          REQ_FREE: begin
            if (w != '0) begin
              rsp.status = ST_REFERENCED;
            end else begin
              block_word[rq.index] = chunk_head[c];
              chunk_head[c] = rq.index % BlocksPerChunk;
              if (chunk_used[c] > 0) chunk_used[c]--;
              block_held[rq.index] = 1'b0;
            end
          end
          REQ_ADD: begin
            rsp.prior = w;
            block_word[rq.index] = w + rq.delta;
          end
          REQ_SUB: begin
            rsp.prior = w;
            if (w < rq.delta) rsp.status = ST_UNDERFLOW;
            else block_word[rq.index] = w - rq.delta;
          end
          default: begin
            rsp.prior = w;
          end
        endcase
      end
    end
    return rsp;
  endfunction

  // Driver: feeds queued requests, holding each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_responses.push_back(allocator_response(in_flight));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_W'({in_flight.delta, in_flight.index, in_flight.kind});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string label, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks every response transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t ns: response with none pending, expected nothing, actual %h",
                   $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          response_t want;
          want = expected_responses.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(m_axis_tdata[2:0]));
          check_field("granted_index", WORD_W'(want.granted), WORD_W'(m_axis_tdata[10:3]));
          check_field("prior_count", want.prior, m_axis_tdata[42:11]);
          check_field("zero fill", '0, WORD_W'(m_axis_tdata[TDATA_W-1:PAYLOAD_W]));
          status_seen[want.status]++;
          responses_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_req(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] index,
                          logic [WORD_W-1:0] delta);
    request_t rq;
    rq.kind  = kind;
    rq.index = index;
    rq.delta = delta;
    pending_requests.push_back(rq);
    items_issued++;
  endtask

  // Wait until every queued request has been transferred, so the model is current
  task automatic sync_to_model();
    while (pending_requests.size() != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_responses.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_delta();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed opening, a full-pool fill, then random episodes per phase
  initial begin
    int unsigned       slot, pick, n, target, fill_guard, ph;
    logic [WORD_W-1:0] cnt, amt;
    int unsigned       held_slots[$];
    reset_pool_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_gap_pct[ph];
      recv_idle_pct = recv_stall_pct[ph];
      target = items_issued + PHASE_ITEMS;

      if (ph == 0) begin
        // nothing open yet: out of range, then no-op request codes
        push_req(REQ_READ, 8'd0, '0);
        push_req(REQ_FREE, 8'd255, '1);
        push_req(REQ_UNUSED_LAST, 8'hFF, '1);
        push_req(REQ_UNUSED_FIRST, 8'h00, '0);
        // count arithmetic on block 0: wrap, underflow, referenced free
        push_req(REQ_ALLOC, '0, '0);
        push_req(REQ_READ, 8'd0, '0);
        push_req(REQ_ADD, 8'd0, '1);
        push_req(REQ_ADD, 8'd0, 32'd1);
        push_req(REQ_ADD, 8'd0, 32'd5);
        push_req(REQ_SUB, 8'd0, 32'd6);
        push_req(REQ_FREE, 8'd0, '0);
        push_req(REQ_SUB, 8'd0, 32'd5);
        push_req(REQ_FREE, 8'd0, '0);
        push_req(REQ_FREE, 8'd0, '0);
        push_req(REQ_ADD, 8'd64, 32'd1);
        // corrupt the link of free block 1, so chunk 0 turns full after two allocs
        push_req(REQ_ADD, 8'd1, 32'd200);
        push_req(REQ_ALLOC, '0, '0);
        push_req(REQ_ALLOC, '1, '1);
        push_req(REQ_ALLOC, '0, '0);
        // underflowing subtract on never-allocated block 65, free of 64, referenced free of 65
        push_req(REQ_SUB, 8'd65, 32'd66);
        push_req(REQ_FREE, 8'd64, '0);
        push_req(REQ_FREE, 8'd65, '0);
        push_req(REQ_ALLOC, '0, '0);
        push_req(REQ_ADD, 8'd255, '0);
        push_req(REQ_READ, 8'd127, '0);

        // fill the pool until allocs report full, then give back fresh blocks
        fill_guard = 0;
        sync_to_model();
        while (!pool_exhausted() && fill_guard < 320) begin
          repeat (16) push_req(REQ_ALLOC, IDX_W'($urandom), $urandom);
          fill_guard += 16;
          sync_to_model();
        end
        repeat (3) push_req(REQ_ALLOC, IDX_W'($urandom), $urandom);
        sync_to_model();
        for (int s = 0; s < DEPTH; s++) begin
          if (block_held[s] && block_word[s] == '0 && $urandom_range(1))
            push_req(REQ_FREE, IDX_W'(s), pick_delta());
        end
      end

      while (items_issued < target) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          // life of one held block: add, read, optional early free, subtracts to zero, free
          sync_to_model();
          held_slots.delete();
          for (int s = 0; s < DEPTH; s++) if (block_held[s]) held_slots.push_back(s);
          if (held_slots.size() == 0) begin
            push_req(REQ_ALLOC, '0, '0);
          end else begin
            slot = held_slots[$urandom_range(held_slots.size() - 1)];
            cnt = block_word[slot];
            amt = ($urandom_range(3) == 0) ? pick_delta() : WORD_W'($urandom_range(1, 9));
            push_req(REQ_ADD, IDX_W'(slot), amt);
            cnt = cnt + amt;
            push_req(REQ_READ, IDX_W'(slot), pick_delta());
            if ($urandom_range(1)) push_req(REQ_FREE, IDX_W'(slot), '0);
            amt = (cnt != '1 && $urandom_range(1)) ? cnt + 1 : WORD_W'($urandom_range(cnt));
            push_req(REQ_SUB, IDX_W'(slot), amt);
            if (amt <= cnt) cnt = cnt - amt;
            push_req(REQ_SUB, IDX_W'(slot), cnt);
            push_req(REQ_FREE, IDX_W'(slot), pick_delta());
            if ($urandom_range(3) == 0) push_req(REQ_FREE, IDX_W'(slot), '0);
          end
        end else if (pick < 65) begin
          n = $urandom_range(1, 6);
          repeat (n) push_req(REQ_ALLOC, IDX_W'($urandom), $urandom);
        end else if (pick < 80) begin
          // return a few unreferenced blocks; clear one count if none are
          sync_to_model();
          held_slots.delete();
          for (int s = 0; s < DEPTH; s++) if (block_held[s]) held_slots.push_back(s);
          held_slots.shuffle();
          n = 0;
          foreach (held_slots[k]) begin
            if (n < 6 && block_word[held_slots[k]] == '0) begin
              push_req(REQ_FREE, IDX_W'(held_slots[k]), '0);
              n++;
            end
          end
          if (n == 0 && held_slots.size() != 0) begin
            push_req(REQ_SUB, IDX_W'(held_slots[0]), block_word[held_slots[0]]);
            push_req(REQ_FREE, IDX_W'(held_slots[0]), '0);
          end
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) push_req(REQ_W'($urandom_range(7)), IDX_W'($urandom_range(255)),
                              pick_delta());
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("ran %0d requests over four flow-control phases, %0d responses checked",
             items_issued, responses_checked);
    $display("responses by status: ok %0d, full %0d, range %0d, referenced %0d, underflow %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_REFERENCED], status_seen[ST_UNDERFLOW]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(5_000_000);
    $display("timeout with %0d responses outstanding", expected_responses.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
